@@ src/tournament_tree_min_select_macros.svh @@
// ----------------------------------------------------------------------------
// Tournament tree minimum select - assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_TREE_MIN_SELECT_MACROS_SVH
`define TOURNAMENT_TREE_MIN_SELECT_MACROS_SVH

// Same-cycle implication
`define TTMS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tournament tree check failed");

// Next-cycle implication
`define TTMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tournament tree check failed");

`endif

@@ src/ttms_pkg.sv @@
// ----------------------------------------------------------------------------
// Tournament tree minimum select - package
// Sizes, operation codes, payload types and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ttms_pkg;

    // Tree sizing
    localparam int MAX_WAYS = 16;
    localparam int KEY_BITS = 32;
    localparam int WAY_W    = $clog2(MAX_WAYS);
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);

    // Operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_BUILD   = 2'd1;
    localparam logic [1:0] OP_REPLACE = 2'd2;

    // Input transaction
    typedef struct packed {
        logic [1:0]          operation;
        logic [WAY_W-1:0]    way_index;
        logic [KEY_BITS-1:0] key;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [WAY_W-1:0]    winner_way;
        logic [KEY_BITS-1:0] winner_key;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_key;      // write the incoming key into its way
        logic start_build;   // first node = ways - 1, walk downwards
        logic start_replace; // rewrite winner key, first node = parent of its leaf
        logic latch_pair;    // contenders resolved, key reads issued
        logic play;          // compare and record the node winner
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_node;     // current node is the root
    } t_dp_status;

endpackage

`default_nettype wire

@@ src/ttms_ram.sv @@
// ----------------------------------------------------------------------------
// Tournament tree minimum select - generic RAM
// One write port, two read ports with registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ttms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ src/ttms_cfg.sv @@
// ----------------------------------------------------------------------------
// Tournament tree minimum select - configuration registers
// APB-style register holding the way count, clamped on write.
// ----------------------------------------------------------------------------
`default_nettype none

module ttms_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [2:0]                 i_paddr,
    input  wire logic [31:0]                i_pwdata,
    output logic      [31:0]                o_prdata,
    output logic                            o_pready,
    output logic      [ttms_pkg::CNT_W-1:0] o_ways
);

    localparam logic [ttms_pkg::CNT_W-1:0] MIN_WAYS = ttms_pkg::CNT_W'(2);
    localparam logic [ttms_pkg::CNT_W-1:0] TOP_WAYS = ttms_pkg::CNT_W'(ttms_pkg::MAX_WAYS);

    logic [ttms_pkg::CNT_W-1:0] r_ways_q;
    logic [ttms_pkg::CNT_W-1:0] n_ways;
    logic [ttms_pkg::CNT_W-1:0] w_raw;
    logic                       w_sel_ways;
    logic                       w_wr;

    // One register, decoded at addresses 0 to 3; address bit 2 selects beyond it
    assign w_sel_ways = ~i_paddr[2];
    assign w_wr       = i_psel & i_penable & i_pwrite & w_sel_ways;
    assign w_raw      = i_pwdata[ttms_pkg::CNT_W-1:0];

    // Clamp to the supported way range
    always_comb begin
        if (w_raw < MIN_WAYS) begin
            n_ways = MIN_WAYS;
        end else if (w_raw > TOP_WAYS) begin
            n_ways = TOP_WAYS;
        end else begin
            n_ways = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_q <= TOP_WAYS;
        end else if (w_wr) begin
            r_ways_q <= n_ways;
        end
    end

    assign o_ways   = r_ways_q;
    assign o_pready = 1'b1;
    assign o_prdata = w_sel_ways ? {{(32 - ttms_pkg::CNT_W){1'b0}}, r_ways_q} : 32'd0;

endmodule

`default_nettype wire

@@ src/ttms_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tournament tree minimum select - controller
// Accepts operations and sequences each node through read, key read and play.
// ----------------------------------------------------------------------------
`default_nettype none

module ttms_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [1:0]           i_op,
    input  ttms_pkg::t_dp_status      i_status,
    output ttms_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_NODE = 4'b0010,
        S_KEY  = 4'b0100,
        S_PLAY = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        ttms_pkg::OP_LOAD: begin
                            o_cmd.load_key = 1'b1;
                        end
                        ttms_pkg::OP_BUILD: begin
                            o_cmd.start_build = 1'b1;
                            n_state           = S_NODE;
                        end
                        ttms_pkg::OP_REPLACE: begin
                            o_cmd.start_replace = 1'b1;
                            n_state             = S_NODE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // child winner reads are in flight
            S_NODE: begin
                n_state = S_KEY;
            end
            S_KEY: begin
                o_cmd.latch_pair = 1'b1;
                n_state          = S_PLAY;
            end
            S_PLAY: begin
                o_cmd.play = 1'b1;
                n_state    = i_status.last_node ? S_IDLE : S_NODE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ src/ttms_dp.sv @@
// ----------------------------------------------------------------------------
// Tournament tree minimum select - datapath
// Key store, node winner store, node pointer, comparator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttms_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  ttms_pkg::t_dp_cmd               i_cmd,
    input  ttms_pkg::t_in_item              i_item,
    input  wire logic [ttms_pkg::CNT_W-1:0] i_ways,
    output ttms_pkg::t_dp_status            o_status,
    output logic                            o_done,
    output ttms_pkg::t_out_item             o_result
);

    localparam int WW = ttms_pkg::WAY_W;
    localparam int CW = ttms_pkg::CNT_W;
    localparam int KB = ttms_pkg::KEY_BITS;

    // Control registers
    logic [WW-1:0] r_p;
    logic [WW-1:0] n_p;
    logic          r_build;
    logic [WW-1:0] r_top;
    logic          r_done;

    // Payload registers
    logic [WW-1:0] r_l;
    logic [WW-1:0] r_r;
    ttms_pkg::t_out_item r_result;

    // Node geometry
    logic [CW-1:0] w_twop;
    logic [CW-1:0] w_twop1;
    logic [CW-1:0] w_n_m1;
    logic [CW-1:0] w_rep_sum;
    logic [CW-1:0] w_leaf_l;
    logic [CW-1:0] w_leaf_r;
    logic          w_odd_node;
    logic          w_inner;

    // Memory ports
    logic [WW-1:0] w_nw_ra;
    logic [WW-1:0] w_nw_rb;
    logic [WW-1:0] w_nw_da;
    logic [WW-1:0] w_nw_db;
    logic          w_key_we;
    logic [WW-1:0] w_key_wa;
    logic [WW-1:0] w_l_sel;
    logic [WW-1:0] w_r_sel;
    logic [KB-1:0] w_key_a;
    logic [KB-1:0] w_key_b;

    // Play
    logic          w_gt;
    logic [WW-1:0] w_win;
    logic [KB-1:0] w_win_key;

    // Children of node p are 2p and 2p+1; leaves sit at ways + way
    assign w_twop     = {r_p, 1'b0};
    assign w_twop1    = {r_p, 1'b1};
    assign w_n_m1     = i_ways - CW'(1);
    assign w_rep_sum  = {1'b0, r_top} + i_ways;
    assign w_leaf_l   = w_twop - i_ways;
    assign w_leaf_r   = w_twop1 - i_ways;
    // odd count: way 0 leaf against the winner of node ways-1
    assign w_odd_node = (i_ways == w_twop1);
    assign w_inner    = ({1'b0, r_p} < (i_ways >> 1));

    // Child winner reads
    assign w_nw_ra = w_twop[WW-1:0];
    assign w_nw_rb = w_odd_node ? w_n_m1[WW-1:0] : w_twop1[WW-1:0];

    // Contender ways, valid in the key read cycle
    always_comb begin
        priority if (w_odd_node) begin
            w_l_sel = '0;
            w_r_sel = w_nw_db;
        end else if (w_inner) begin
            w_l_sel = w_nw_da;
            w_r_sel = w_nw_db;
        end else begin
            w_l_sel = w_leaf_l[WW-1:0];
            w_r_sel = w_leaf_r[WW-1:0];
        end
    end

    // Key write: load targets its way, replace targets the current winner
    assign w_key_we = i_cmd.load_key | i_cmd.start_replace;
    assign w_key_wa = i_cmd.start_replace ? r_top : i_item.way_index;

    ttms_ram #(
        .WIDTH (KB),
        .DEPTH (ttms_pkg::MAX_WAYS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (w_key_we),
        .i_waddr   (w_key_wa),
        .i_wdata   (i_item.key),
        .i_raddr_a (w_l_sel),
        .i_raddr_b (w_r_sel),
        .o_rdata_a (w_key_a),
        .o_rdata_b (w_key_b)
    );

    ttms_ram #(
        .WIDTH (WW),
        .DEPTH (ttms_pkg::MAX_WAYS)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.play),
        .i_waddr   (r_p),
        .i_wdata   (w_win),
        .i_raddr_a (w_nw_ra),
        .i_raddr_b (w_nw_rb),
        .o_rdata_a (w_nw_da),
        .o_rdata_b (w_nw_db)
    );

    // Compare: left wins on equal keys
    assign w_gt      = (w_key_a > w_key_b);
    assign w_win     = w_gt ? r_r : r_l;
    assign w_win_key = w_gt ? w_key_b : w_key_a;

    // Node pointer step
    always_comb begin
        priority if (i_cmd.start_build) begin
            n_p = w_n_m1[WW-1:0];
        end else if (i_cmd.start_replace) begin
            n_p = w_rep_sum[CW-1:1];
        end else if (i_cmd.play) begin
            n_p = r_build ? (r_p - WW'(1)) : (r_p >> 1);
        end else begin
            n_p = r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p     <= '0;
            r_build <= 1'b0;
            r_top   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_p    <= n_p;
            r_done <= i_cmd.play & o_status.last_node;
            if (i_cmd.start_build | i_cmd.start_replace) begin
                r_build <= i_cmd.start_build;
            end
            if (i_cmd.play & o_status.last_node) begin
                r_top <= w_win;
            end
        end
    end

    // Contender and result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_pair) begin
            r_l <= w_l_sel;
            r_r <= w_r_sel;
        end
        if (i_cmd.play & o_status.last_node) begin
            r_result.winner_way <= w_win;
            r_result.winner_key <= w_win_key;
        end
    end

    assign o_status.last_node = (r_p == WW'(1));
    assign o_done             = r_done;
    assign o_result           = r_result;

endmodule

`default_nettype wire

@@ src/tournament_tree_min_select.sv @@
// ----------------------------------------------------------------------------
// Tournament tree minimum select - top level
// Selects the way holding the smallest key; build plays the whole tree, replace
// rewrites the winner's key and replays its path to the root.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A load gives no
// result. Each tree node steps through child winner read, key read and
// compare/write, set by the two registered-read stores in series. A build
// plays ways_in_use-1 nodes, a replace the nodes on the leaf-to-root path
// (4 nodes at 16 ways); the result register is loaded as the root is played.
// The result is shown for a single cycle with o_done high and
// cannot be held off, so the receiver must take it in that cycle. busy is low
// again in the cycle the result is shown, so the next transaction may start.
// No memory clearing runs after reset; keys must be loaded before a build.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_tree_min_select (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Command channel
    input  wire logic         start,
    output logic              busy,
    input  ttms_pkg::t_in_item i_item,
    // Result channel
    output logic              o_done,
    output ttms_pkg::t_out_item o_result,
    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    `include "tournament_tree_min_select_macros.svh"

    logic [ttms_pkg::CNT_W-1:0] w_ways;
    ttms_pkg::t_dp_cmd          w_cmd;
    ttms_pkg::t_dp_status       w_status;

    // Way count register
    ttms_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_ways    (w_ways)
    );

    // Sequencer
    ttms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.operation),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // Stores and comparator
    ttms_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .i_ways   (w_ways),
        .o_status (w_status),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Checks
    `TTMS_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `TTMS_ASSERT_IMPL(a_done_idle, o_done, !busy)
    `TTMS_ASSERT_IMPL(a_ways_range, 1'b1, (w_ways >= 5'd2) && (w_ways <= 5'd16))
    `TTMS_ASSERT_NEXT(a_build_busy, start && !busy && (i_item.operation == ttms_pkg::OP_BUILD), busy)

endmodule

`default_nettype wire

@@ tb/sv/tree_winner_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament tree minimum select - winner checker
// Watches the command, result and register channels, keeps its own copy of
// the key store and node winners, and compares every result with the oldest
// predicted winner. The failure count and the number of outstanding winners
// go back to the testbench top.
// ----------------------------------------------------------------------------

module tree_winner_checker #(
    parameter logic [2:0] P_WAYS_ADDR = 3'd0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Command channel
    input  logic                i_start,
    input  logic                i_busy,
    input  ttms_pkg::t_in_item  i_item,
    // Result channel
    input  logic                i_done,
    input  ttms_pkg::t_out_item i_result,
    // Register port
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    input  logic [31:0]         i_prdata,
    input  logic                i_pready,
    // Status back to the top
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked
);

    // Shadow of the tree state
    logic [ttms_pkg::KEY_BITS-1:0] key_mem  [ttms_pkg::MAX_WAYS];
    logic [ttms_pkg::WAY_W-1:0]    node_win [ttms_pkg::MAX_WAYS];
    logic [ttms_pkg::WAY_W-1:0]    top_way;
    int unsigned                   ways;

    // Winners predicted but not yet seen on the result port
    ttms_pkg::t_out_item           winner_q [$];
    int                            errs;
    int                            checked;

    // Play one node: leaf pair, two internal children, or the odd-count mixed node
    function automatic void play_match(input int unsigned p);
        int unsigned l;
        int unsigned r;
        if (ways == 2 * p + 1) begin
            l = 0;
            r = 32'(node_win[(ways - 1) % ttms_pkg::MAX_WAYS]);
        end else if (p < ways / 2) begin
            l = 32'(node_win[(2 * p) % ttms_pkg::MAX_WAYS]);
            r = 32'(node_win[(2 * p + 1) % ttms_pkg::MAX_WAYS]);
        end else begin
            l = (2 * p - ways) % ttms_pkg::MAX_WAYS;
            r = (2 * p + 1 - ways) % ttms_pkg::MAX_WAYS;
        end
        // left contender keeps the node on a tie
        if (key_mem[l] > key_mem[r])
            node_win[p % ttms_pkg::MAX_WAYS] = r[ttms_pkg::WAY_W-1:0];
        else
            node_win[p % ttms_pkg::MAX_WAYS] = l[ttms_pkg::WAY_W-1:0];
    endfunction

    // Apply one accepted command; build and replace queue their winner
    function automatic void apply_command(input ttms_pkg::t_in_item it);
        int unsigned         p;
        ttms_pkg::t_out_item res;
        if (it.operation == ttms_pkg::OP_LOAD) begin
            key_mem[it.way_index] = it.key;
        end else if (it.operation == ttms_pkg::OP_BUILD ||
                     it.operation == ttms_pkg::OP_REPLACE) begin
            if (it.operation == ttms_pkg::OP_BUILD) begin
                for (p = ways - 1; p != 0; p--)
                    play_match(p);
            end else begin
                key_mem[top_way] = it.key;
                for (p = (top_way + ways) / 2; p != 0; p = p / 2)
                    play_match(p);
            end
            top_way        = node_win[1];
            res.winner_way = top_way;
            res.winner_key = key_mem[top_way];
            winner_q.push_back(res);
        end
        // unused code: nothing changes
    endfunction

    always @(posedge i_clk) begin
        ttms_pkg::t_out_item want;
        logic [4:0]          wval;
        if (!i_rst_n) begin
            for (int i = 0; i < ttms_pkg::MAX_WAYS; i++) begin
                key_mem[i]  = '0;
                node_win[i] = '0;
            end
            top_way = '0;
            ways    = ttms_pkg::MAX_WAYS;
            winner_q.delete();
            errs    = 0;
            checked = 0;
        end else begin
            // Register transaction: track writes, check read data
            if (i_psel && i_penable && i_pready && i_paddr == P_WAYS_ADDR) begin
                if (i_pwrite) begin
                    wval = i_pwdata[4:0];
                    if (wval < 2)
                        ways = 2;
                    else if (wval > ttms_pkg::MAX_WAYS)
                        ways = ttms_pkg::MAX_WAYS;
                    else
                        ways = 32'(wval);
                end else if (i_prdata[ttms_pkg::CNT_W-1:0] !==
                             ways[ttms_pkg::CNT_W-1:0]) begin
                    $display("%0t: ways_in_use read mismatch: expected %0d, got %0d",
                             $time, ways, i_prdata[ttms_pkg::CNT_W-1:0]);
                    errs++;
                end
            end

            // Result transaction against the oldest prediction
            if (i_done) begin
                if (winner_q.size() == 0) begin
                    $display("%0t: unexpected result: way %0d key %h",
                             $time, i_result.winner_way, i_result.winner_key);
                    errs++;
                end else begin
                    want = winner_q.pop_front();
                    checked++;
                    if (i_result.winner_way !== want.winner_way) begin
                        $display("%0t: winner_way mismatch: expected %0d, got %0d",
                                 $time, want.winner_way, i_result.winner_way);
                        errs++;
                    end
                    if (i_result.winner_key !== want.winner_key) begin
                        $display("%0t: winner_key mismatch: expected %h, got %h",
                                 $time, want.winner_key, i_result.winner_key);
                        errs++;
                    end
                end
            end

            // Command transaction
            if (i_start && !i_busy)
                apply_command(i_item);
        end
        o_errors  <= errs;
        o_pending <= winner_q.size();
        o_checked <= checked;
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament tree minimum select - testbench top
// Drives loads, builds and replaces with random gaps across a range of way
// counts, including out-of-range register writes, and leaves prediction and
// comparison to the winner checker. Gives the verdict at the end of the run.
// ----------------------------------------------------------------------------

module testbench;

    localparam logic [2:0] WAYS_ADDR     = 3'd0;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         RANDOM_TARGET = 550;
    localparam int         TAIL_CYCLES   = 60;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    ttms_pkg::t_in_item  i_item;
    logic                o_done;
    ttms_pkg::t_out_item o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int          errors;
    int          pending;
    int          checked;

    // Stimulus bookkeeping
    int          gap_cap;
    int          n_load;
    int          n_build;
    int          n_replace;
    int          n_unused;
    int          n_settings;
    int          random_items;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    tournament_tree_min_select dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tree_winner_checker #(
        .P_WAYS_ADDR (WAYS_ADDR)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_done    (o_done),
        .i_result  (o_result),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_prdata  (prdata),
        .i_pready  (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    // Keys lean towards ties and the two extremes
    function automatic logic [31:0] draw_key();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom_range(0, 7);
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One command transaction; called and left at a falling edge
    task automatic issue(input logic [1:0] op, input logic [3:0] way,
                         input logic [31:0] key);
        int gap;
        gap = $urandom_range(0, gap_cap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{operation: op, way_index: way, key: key};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        case (op)
            ttms_pkg::OP_LOAD:    n_load++;
            ttms_pkg::OP_BUILD:   n_build++;
            ttms_pkg::OP_REPLACE: n_replace++;
            default:              n_unused++;
        endcase
        if (op != OP_UNUSED)
            random_items++;
    endtask

    // Register transaction: setup, access, then idle
    task automatic apb_access(input bit wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= WAYS_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drain: every winner back, block not busy, then a short settle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        int          cfg_seq [] = '{2, 16, 1, 0, 31, 17, 3, 15, 9, 5, 16, 2};
        int          phase;
        int          cfg_val;
        int          n;
        int          len;
        int          r;
        bit          fresh;
        logic [3:0]  way;

        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        gap_cap = 0;
        n_load = 0; n_build = 0; n_replace = 0; n_unused = 0;
        n_settings = 1; random_items = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset way count, ties and extreme keys
        apb_access(1'b0, '0);
        issue(ttms_pkg::OP_LOAD, 4'd0, 32'hFFFF_FFFF);
        issue(ttms_pkg::OP_LOAD, 4'd1, 32'h0000_0005);
        issue(ttms_pkg::OP_LOAD, 4'd2, 32'h0000_0005);
        issue(ttms_pkg::OP_LOAD, 4'd3, 32'hFFFF_FFFE);
        for (int w = 4; w < ttms_pkg::MAX_WAYS; w++)
            issue(ttms_pkg::OP_LOAD, w[3:0], $urandom | 32'h0000_0100);
        issue(ttms_pkg::OP_BUILD, 4'hF, 32'h0000_0000);
        issue(ttms_pkg::OP_REPLACE, 4'h0, 32'h0000_0000);
        issue(ttms_pkg::OP_REPLACE, 4'h0, 32'hFFFF_FFFF);
        issue(ttms_pkg::OP_REPLACE, 4'hF, 32'hFFFF_FFFF);
        issue(OP_UNUSED, 4'h7, 32'h0000_0000);
        issue(ttms_pkg::OP_BUILD, 4'h0, 32'hFFFF_FFFF);
        random_items = 0;

        // Random phases, each under its own way count
        phase = 0;
        while (random_items < RANDOM_TARGET) begin
            wait_idle();
            cfg_val = (phase < cfg_seq.size()) ? cfg_seq[phase] : $urandom_range(0, 31);
            apb_access(1'b1, ($urandom & 32'hFFFF_FFE0) | cfg_val);
            apb_access(1'b0, '0);
            n_settings++;
            n = (cfg_val < 2) ? 2 : (cfg_val > ttms_pkg::MAX_WAYS) ? ttms_pkg::MAX_WAYS
                                                                   : cfg_val;

            case ($urandom_range(0, 3))
                0:       gap_cap = 0;
                1:       gap_cap = 3;
                default: gap_cap = 14;
            endcase

            // Mostly a full refill and build; sometimes replay the old tree
            fresh = (phase == 0) || ($urandom_range(0, 4) != 0);
            if (fresh) begin
                for (int w = 0; w < n; w++)
                    issue(ttms_pkg::OP_LOAD, w[3:0], draw_key());
                issue(ttms_pkg::OP_BUILD, 4'($urandom), $urandom);
            end

            len = $urandom_range(40, 70);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    way = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(0, n - 1));
                    issue(ttms_pkg::OP_LOAD, way, draw_key());
                end else if (r < 82) begin
                    issue(ttms_pkg::OP_REPLACE, 4'($urandom), draw_key());
                end else if (r < 94) begin
                    issue(ttms_pkg::OP_BUILD, 4'($urandom), $urandom);
                end else begin
                    issue(OP_UNUSED, 4'($urandom), $urandom);
                end
            end
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d loads, %0d builds, %0d replaces, %0d unused-code commands",
                 n_load, n_build, n_replace, n_unused);
        $display("over %0d way-count settings; %0d winners compared.", n_settings, checked);
        if (errors == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/ttms_pkg.sv
src/ttms_ram.sv
src/ttms_cfg.sv
src/ttms_ctrl.sv
src/ttms_dp.sv
src/tournament_tree_min_select.sv
tb/sv/tree_winner_checker.sv
tb/sv/testbench.sv
